// ===== design/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COPY_CELLS = COLUMNS * (ROWS - 1);
    localparam int ADDR_W     = $clog2(CELLS);

    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;

    localparam logic [REQ_W-1:0]  REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0]  REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0]  REQ_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] ATTR_NORMAL  = 8'h07;

    typedef enum logic [2:0] {
        PTR_ZERO   = 3'b001,
        PTR_CUR    = 3'b010,
        PTR_BOTTOM = 3'b100
    } t_ptr_sel;

    typedef struct packed {
        logic     accept;
        logic     wr_char;
        logic     rd_issue;
        logic     ptr_load;
        t_ptr_sel ptr_sel;
        logic     end_row;
        logic     fill_step;
        logic     copy_step;
        logic     cur_adv;
        logic     cur_nl;
        logic     cur_home;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic             at_last_col;
        logic             at_last_row;
        logic             is_nl;
        logic             ptr_at_end;
        logic             copy_end;
        logic [COL_W-1:0] cur_col;
        logic [ROW_W-1:0] cur_row;
    } t_status;

endpackage

`default_nettype wire

// ===== design/tcw_if.sv =====
`default_nettype none

interface tcw_req_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::REQ_W-1:0]   req_type;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic                        end_of_string;
    logic [tcw_pkg::ROW_W-1:0]   read_row;
    logic [tcw_pkg::COL_W-1:0]   read_col;

    modport source (
        output valid, req_type, char_code, end_of_string, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, req_type, char_code, end_of_string, read_row, read_col,
        output ready
    );
endinterface

interface tcw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::CELL_W-1:0]  read_cell;
    logic [tcw_pkg::COL_W-1:0]   cursor_col;
    logic [tcw_pkg::ROW_W-1:0]   cursor_row;
    logic                        string_done;

    modport source (
        output valid, read_cell, cursor_col, cursor_row, string_done,
        input  ready
    );
    modport sink (
        input  valid, read_cell, cursor_col, cursor_row, string_done,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
`default_nettype none

module tcw_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [tcw_pkg::REQ_W-1:0] i_req_type,
    output logic                           o_in_ready,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    input  wire tcw_pkg::t_status          i_st,
    output tcw_pkg::t_cmd                  o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_FILL = 5'b00100,
        S_COPY = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_scroll, n_scroll;
    logic   r_out_vld, n_out_vld;

    always_comb begin
        n_state    = r_state;
        n_scroll   = r_scroll;
        o_cmd      = '0;
        o_cmd.ptr_sel = PTR_ZERO;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.fill_step = 1'b1;
                if (i_st.ptr_at_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        REQ_PUT: begin
                            if (i_st.is_nl) begin
                                o_cmd.ptr_load = 1'b1;
                                o_cmd.ptr_sel  = PTR_CUR;
                                o_cmd.end_row  = 1'b1;
                                o_cmd.cur_nl   = 1'b1;
                                n_scroll       = i_st.at_last_row;
                                n_state        = S_FILL;
                            end else begin
                                o_cmd.wr_char = 1'b1;
                                o_cmd.cur_adv = 1'b1;
                                if (i_st.at_last_col && i_st.at_last_row) begin
                                    o_cmd.ptr_load = 1'b1;
                                    n_state        = S_COPY;
                                end else begin
                                    n_state = S_DONE;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            o_cmd.ptr_load = 1'b1;
                            o_cmd.cur_home = 1'b1;
                            n_scroll       = 1'b0;
                            n_state        = S_FILL;
                        end
                        REQ_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_st.ptr_at_end) begin
                    if (r_scroll) begin
                        o_cmd.ptr_load = 1'b1;
                        n_scroll       = 1'b0;
                        n_state        = S_COPY;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_st.copy_end) begin
                    o_cmd.ptr_load = 1'b1;
                    o_cmd.ptr_sel  = PTR_BOTTOM;
                    n_state        = S_FILL;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_scroll  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scroll  <= n_scroll;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

// ===== design/tcw_datapath.sv =====
`default_nettype none

module tcw_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tcw_pkg::t_cmd              i_cmd,
    output tcw_pkg::t_status                o_st,
    input  wire logic [tcw_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                       i_end_of_string,
    input  wire logic [tcw_pkg::ROW_W-1:0]  i_read_row,
    input  wire logic [tcw_pkg::COL_W-1:0]  i_read_col,
    output logic [tcw_pkg::CELL_W-1:0]      o_read_cell,
    output logic [tcw_pkg::COL_W-1:0]       o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]       o_cursor_row,
    output logic                            o_string_done
);
    import tcw_pkg::*;

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(COPY_CELLS);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_end, n_end;
    logic              r_cell_ok;
    logic              r_done;

    logic [CELL_W-1:0] r_out_cell;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_out_done;

    logic [ADDR_W-1:0] w_row_base;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_rd_in_range;
    logic              w_last_col;
    logic              w_last_row;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;

    assign w_row_base    = ADDR_W'(r_row) * COLS_A;
    assign w_cur_addr    = w_row_base + ADDR_W'(r_col);
    assign w_rd_addr     = ADDR_W'(i_read_row) * COLS_A + ADDR_W'(i_read_col);
    assign w_rd_in_range = (i_read_row < ROWS) && (i_read_col < COLUMNS);
    assign w_last_col    = (r_col == COL_W'(COLUMNS - 1));
    assign w_last_row    = (r_row == ROW_W'(ROWS - 1));

    assign o_st.at_last_col = w_last_col;
    assign o_st.at_last_row = w_last_row;
    assign o_st.is_nl       = (i_char_code == NEWLINE_CODE);
    assign o_st.ptr_at_end  = (r_ptr == r_end);
    assign o_st.copy_end    = (r_ptr == BOTTOM_BASE);
    assign o_st.cur_col     = r_col;
    assign o_st.cur_row     = r_row;

    // copy: read one row ahead, write back the word read last cycle
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_cur_addr;
        w_wdata = {ATTR_NORMAL, i_char_code};
        if (i_cmd.wr_char) begin
            w_we = 1'b1;
        end else if (i_cmd.fill_step) begin
            w_we    = 1'b1;
            w_waddr = r_ptr;
            w_wdata = '0;
        end else if (i_cmd.copy_step && (r_ptr != '0)) begin
            w_we    = 1'b1;
            w_waddr = r_ptr - 1'b1;
            w_wdata = r_rd_data;
        end
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = w_rd_addr;
        if (i_cmd.rd_issue) begin
            w_re = w_rd_in_range;
        end else if (i_cmd.copy_step && (r_ptr != BOTTOM_BASE)) begin
            w_re    = 1'b1;
            w_raddr = r_ptr + COLS_A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.cur_home) begin
            n_col = '0;
            n_row = '0;
        end else if (i_cmd.cur_nl || (i_cmd.cur_adv && w_last_col)) begin
            n_col = '0;
            if (!w_last_row) begin
                n_row = r_row + 1'b1;
            end
        end else if (i_cmd.cur_adv) begin
            n_col = r_col + 1'b1;
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        n_end = r_end;
        if (i_cmd.ptr_load) begin
            case (i_cmd.ptr_sel)
                PTR_ZERO:   n_ptr = '0;
                PTR_CUR:    n_ptr = w_cur_addr;
                PTR_BOTTOM: n_ptr = BOTTOM_BASE;
                default:    n_ptr = '0;
            endcase
            n_end = i_cmd.end_row ? (w_row_base + COLS_A - 1'b1) : LAST_CELL;
        end else if (i_cmd.fill_step || i_cmd.copy_step) begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ptr <= '0;
            r_end <= LAST_CELL;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ptr <= n_ptr;
            r_end <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cell_ok <= (i_req_type == REQ_READ) && w_rd_in_range;
            r_done    <= (i_req_type == REQ_PUT) && i_end_of_string;
        end
        if (i_cmd.load_out) begin
            r_out_cell <= r_cell_ok ? r_rd_data : '0;
            r_out_col  <= r_col;
            r_out_row  <= r_row;
            r_out_done <= r_done;
        end
    end

    assign o_read_cell   = r_out_cell;
    assign o_cursor_col  = r_out_col;
    assign o_cursor_row  = r_out_row;
    assign o_string_done = r_out_done;

endmodule

`default_nettype wire

// ===== design/text_console_writer_core.sv =====
// Put or read: idle, then the done state; a newline first blanks the row's rest.
// A scroll copies COPY_CELLS cells up a row, then blanks the bottom row (one
// screen memory port each way). Clear blanks CELLS cells; one word is in flight
// at a time. The result register frees the input side while a word waits on the
// output. Reset: synchronous, active low; then the screen clears with ready low.
`default_nettype none

module text_console_writer_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_req_if.sink   i_req,
    tcw_rsp_if.source o_rsp
);
    import tcw_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_st            (w_st),
        .i_req_type      (i_req.req_type),
        .i_char_code     (i_req.char_code),
        .i_end_of_string (i_req.end_of_string),
        .i_read_row      (i_req.read_row),
        .i_read_col      (i_req.read_col),
        .o_read_cell     (o_rsp.read_cell),
        .o_cursor_col    (o_rsp.cursor_col),
        .o_cursor_row    (o_rsp.cursor_row),
        .o_string_done   (o_rsp.string_done)
    );

    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req.ready)
        else $error("input ready during screen clear after reset");

    a_one_word_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("input accepted on consecutive cycles");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_st.cur_col < COLUMNS) && (w_st.cur_row < ROWS))
        else $error("cursor outside the screen");

endmodule

`default_nettype wire

// ===== test/tb_text_console_writer_core.sv =====
`timescale 1ns / 1ps

module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TOTAL  = 1900;
    localparam int CALM_TAIL   = 200;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic              end_of_string;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_console_req;

    typedef struct packed {
        logic [CELL_W-1:0] read_cell;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              string_done;
    } t_console_word;

    typedef struct packed {
        t_console_req  req;
        logic          typed;
        t_console_word word;
    } t_directed_row;

    localparam t_directed_row DIRECTED [22] = '{
        '{'{REQ_READ,   8'h00, 1'b0, 5'd0,  7'd0  }, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
        '{'{REQ_READ,   8'h00, 1'b0, 5'd24, 7'd79 }, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
        '{'{REQ_READ,   8'hFF, 1'b1, 5'd31, 7'd127}, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
        '{'{REQ_PUT,    8'h41, 1'b1, 5'd0,  7'd0  }, 1'b1, '{16'h0000, 7'd1, 5'd0, 1'b1}},
        '{'{REQ_READ,   8'h00, 1'b0, 5'd0,  7'd0  }, 1'b1, '{16'h0741, 7'd1, 5'd0, 1'b0}},
        '{'{REQ_PUT,    8'hFF, 1'b0, 5'd0,  7'd0  }, 1'b1, '{16'h0000, 7'd2, 5'd0, 1'b0}},
        '{'{REQ_PUT,    8'h00, 1'b1, 5'd31, 7'd127}, 1'b1, '{16'h0000, 7'd3, 5'd0, 1'b1}},
        '{'{REQ_READ,   8'h00, 1'b0, 5'd0,  7'd2  }, 1'b1, '{16'h0700, 7'd3, 5'd0, 1'b0}},
        '{'{REQ_READ,   8'h00, 1'b0, 5'd0,  7'd1  }, 1'b1, '{16'h07FF, 7'd3, 5'd0, 1'b0}},
        '{'{REQ_PUT,    8'h0A, 1'b1, 5'd0,  7'd0  }, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b1}},
        '{'{REQ_READ,   8'h00, 1'b0, 5'd0,  7'd3  }, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
        '{'{REQ_UNUSED, 8'hFF, 1'b1, 5'd31, 7'd127}, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
        '{'{REQ_READ,   8'h00, 1'b0, 5'd25, 7'd0  }, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
        '{'{REQ_READ,   8'h00, 1'b0, 5'd0,  7'd80 }, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
        '{'{REQ_PUT,    8'h0A, 1'b0, 5'd0,  7'd0  }, 1'b1, '{16'h0000, 7'd0, 5'd2, 1'b0}},
        '{'{REQ_PUT,    8'h7E, 1'b1, 5'd0,  7'd0  }, 1'b1, '{16'h0000, 7'd1, 5'd2, 1'b1}},
        '{'{REQ_CLEAR,  8'hFF, 1'b1, 5'd31, 7'd127}, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
        '{'{REQ_READ,   8'h00, 1'b0, 5'd2,  7'd0  }, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}},
        '{'{REQ_PUT,    8'h0A, 1'b0, 5'd0,  7'd0  }, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}},
        '{'{REQ_PUT,    8'h80, 1'b0, 5'd17, 7'd64 }, 1'b0, '0},
        '{'{REQ_PUT,    8'h3C, 1'b1, 5'd8,  7'd33 }, 1'b0, '0},
        '{'{REQ_READ,   8'h55, 1'b1, 5'd1,  7'd1  }, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    tcw_req_if req_bus ();
    tcw_rsp_if rsp_bus ();

    text_console_writer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic [CELL_W-1:0] shadow_cells [CELLS];
    int                shadow_col;
    int                shadow_row;
    t_console_word     expected_words [$];
    int                words_sent;
    int                idle_pct;
    int                mismatch_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void blank_console();
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    function automatic t_console_word console_step(input t_console_req r);
        t_console_word w;
        int            base;
        w = '0;
        case (r.req_type)
            REQ_PUT: begin
                base = shadow_row * COLUMNS;
                if (r.char_code == NEWLINE_CODE) begin
                    for (int i = shadow_col; i < COLUMNS; i++) shadow_cells[base + i] = '0;
                    shadow_col = 0;
                    shadow_row++;
                end else begin
                    shadow_cells[base + shadow_col] = {ATTR_NORMAL, r.char_code};
                    shadow_col++;
                end
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= ROWS) begin
                    for (int i = 0; i < COPY_CELLS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
                    for (int i = COPY_CELLS; i < CELLS; i++) shadow_cells[i] = '0;
                    shadow_row = ROWS - 1;
                end
                w.string_done = r.end_of_string;
            end
            REQ_CLEAR: blank_console();
            REQ_READ: begin
                if (r.read_row < ROWS && r.read_col < COLUMNS)
                    w.read_cell = shadow_cells[r.read_row * COLUMNS + r.read_col];
            end
            default: ;
        endcase
        w.cursor_col = COL_W'(shadow_col);
        w.cursor_row = ROW_W'(shadow_row);
        return w;
    endfunction

    function automatic t_console_req random_word(input logic [REQ_W-1:0] kind);
        t_console_req r;
        r.req_type      = kind;
        r.char_code     = CHAR_W'($urandom);
        r.end_of_string = 1'($urandom);
        r.read_row      = ROW_W'($urandom);
        r.read_col      = COL_W'($urandom);
        return r;
    endfunction

    task automatic send_word(input t_console_req r, input logic typed, input t_console_word w);
        int gap;
        if (words_sent % CALM_TAIL == 0) begin
            case ($urandom_range(2))
                0: idle_pct = 0;
                1: idle_pct = 6;
                default: idle_pct = 30;
            endcase
        end
        if (words_sent >= ITEM_TOTAL - CALM_TAIL) idle_pct = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(19, 1);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= r.req_type;
        req_bus.char_code     <= r.char_code;
        req_bus.end_of_string <= r.end_of_string;
        req_bus.read_row      <= r.read_row;
        req_bus.read_col      <= r.read_col;
        do @(posedge i_clk); while (!req_bus.ready);
        if (typed) begin
            void'(console_step(r));
            expected_words.push_back(w);
        end else begin
            expected_words.push_back(console_step(r));
        end
        words_sent++;
    endtask

    // response side back-pressure
    initial begin : rsp_stall
        int gap;
        rsp_bus.ready <= 1'b0;
        forever begin
            if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                gap = $urandom_range(19, 1);
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : word_check
        t_console_word want;
        if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: cell %h col %0d row %0d done %0b",
                       rsp_bus.read_cell, rsp_bus.cursor_col, rsp_bus.cursor_row,
                       rsp_bus.string_done);
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                if (rsp_bus.read_cell !== want.read_cell) begin
                    $error("read_cell: expected %h, got %h", want.read_cell, rsp_bus.read_cell);
                    mismatch_count++;
                end
                if (rsp_bus.cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d",
                           want.cursor_col, rsp_bus.cursor_col);
                    mismatch_count++;
                end
                if (rsp_bus.cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d",
                           want.cursor_row, rsp_bus.cursor_row);
                    mismatch_count++;
                end
                if (rsp_bus.string_done !== want.string_done) begin
                    $error("string_done: expected %0b, got %0b",
                           want.string_done, rsp_bus.string_done);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        t_console_req  item;
        int            kind;
        int            len;
        logic [CHAR_W-1:0] ch;
        mismatch_count = 0;
        words_sent     = 0;
        idle_pct       = 0;
        blank_console();
        i_rst_n               <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.req_type      <= REQ_PUT;
        req_bus.char_code     <= '0;
        req_bus.end_of_string <= 1'b0;
        req_bus.read_row      <= '0;
        req_bus.read_col      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_word(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].word);

        while (words_sent < ITEM_TOTAL) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                // text string, sparse newlines
                len = $urandom_range(30, 1);
                for (int k = 0; k < len; k++) begin
                    item = random_word(REQ_PUT);
                    if ($urandom_range(99) < 8) item.char_code = NEWLINE_CODE;
                    item.end_of_string = (k == len - 1);
                    send_word(item, 1'b0, '0);
                end
            end else if (kind < 65) begin
                // long line without newlines, to make a wrap likely
                len = $urandom_range(100, 70);
                for (int k = 0; k < len; k++) begin
                    item = random_word(REQ_PUT);
                    ch = item.char_code;
                    if (ch == NEWLINE_CODE) item.char_code = 8'h20;
                    item.end_of_string = (k == len - 1);
                    send_word(item, 1'b0, '0);
                end
            end else if (kind < 90) begin
                len = $urandom_range(4, 1);
                for (int k = 0; k < len; k++) begin
                    item = random_word(REQ_READ);
                    case ($urandom_range(9))
                        0: ;
                        1, 2, 3: begin
                            item.read_row = ROW_W'(shadow_row);
                            item.read_col = COL_W'($urandom_range(COLUMNS - 1));
                        end
                        default: begin
                            item.read_row = ROW_W'($urandom_range(ROWS - 1));
                            item.read_col = COL_W'($urandom_range(COLUMNS - 1));
                        end
                    endcase
                    send_word(item, 1'b0, '0);
                end
            end else if (kind < 94) begin
                send_word(random_word(REQ_CLEAR), 1'b0, '0);
            end else if (kind < 97) begin
                send_word(random_word(REQ_UNUSED), 1'b0, '0);
            end else begin
                send_word(random_word(REQ_PUT), 1'b0, '0);
            end
        end
        req_bus.valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== text_console_writer_core.f =====
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer_core.sv
test/tb_text_console_writer_core.sv
